/* sv/instrument_envelope_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Instrument envelope sequencer assertion macros
// Concurrent property wrappers clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INSTRUMENT_ENVELOPE_SEQUENCER_ASSERT_SVH
`define INSTRUMENT_ENVELOPE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define IES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ies_pkg.sv */
// ----------------------------------------------------------------------------
// Instrument envelope sequencer package
// Shared constants, register map, operation codes and beat payload types.
// ----------------------------------------------------------------------------
package ies_pkg;

  localparam int NUM_SEQUENCES   = 5;
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int SETUP_W         = 27;
  localparam int DVOL_W          = 5;
  localparam int CFG_AW          = 5;
  localparam int CFG_DW          = 32;

  localparam logic [DVOL_W-1:0] DVOL_RESET = 5'd15;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_CUT      = 3'd3,
    OP_WRITE    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_VOLUME_SETUP   = 3'd0,
    REG_ARPEGGIO_SETUP = 3'd1,
    REG_PITCH_SETUP    = 3'd2,
    REG_HIPITCH_SETUP  = 3'd3,
    REG_DUTY_SETUP     = 3'd4,
    REG_DEFAULT_VOLUME = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEQ_STOP = 2'd0,
    SEQ_PLAY = 2'd1,
    SEQ_REL  = 2'd2
  } seq_state_t;

  typedef struct packed {
    logic [7:0] rel;
    logic       rel_on;
    logic [7:0] loop;
    logic       loop_on;
    logic [7:0] len;
    logic       en;
  } setup_t;

  typedef struct packed {
    logic        [2:0] op;
    logic        [2:0] table_select;
    logic        [7:0] entry_index;
    logic signed [7:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] volume_value;
    logic signed [7:0] arpeggio_value;
    logic signed [7:0] pitch_value;
    logic signed [7:0] hipitch_value;
    logic signed [7:0] duty_value;
    logic        [4:0] playing_mask;
    logic        [4:0] releasing_mask;
  } out_item_t;

endpackage

/* sv/instrument_envelope_sequencer.sv */
// ----------------------------------------------------------------------------
// Instrument envelope sequencer
// Table write, cut and unused ops go from acceptance straight to the result
// state; tick, note on and note off first pass through one shared per-sequence
// step unit (a calc step per sequence, plus a read step when it reads the
// single table port). A new beat is taken the cycle after the result loads.
// Reset: synchronous; all sequences stop at position 0 with output 0.
// ----------------------------------------------------------------------------
module instrument_envelope_sequencer #(
  parameter int TABLE_DEPTH = ies_pkg::DEF_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ies_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ies_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ies_pkg::CFG_AW-1:0] paddr,
  input  logic [ies_pkg::CFG_DW-1:0] pwdata,
  output logic [ies_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import ies_pkg::*;

  localparam int TIDX_W = $clog2(TABLE_DEPTH);
  localparam int SEL_W  = $clog2(NUM_SEQUENCES);
  localparam logic [8:0]       DEPTH_LIM = 9'(TABLE_DEPTH);
  localparam logic [SEL_W-1:0] LAST_SEQ  = SEL_W'(NUM_SEQUENCES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_FIN
  } fsm_t;

  fsm_t              fsm_r;
  logic [SEL_W-1:0]  seq_r;
  logic [2:0]        op_r;
  logic              rd_ok_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  setup_t            setup_r   [NUM_SEQUENCES];
  logic [DVOL_W-1:0] dvol_r;
  seq_state_t        sstate_r  [NUM_SEQUENCES];
  logic [7:0]        pos_r     [NUM_SEQUENCES];
  logic [7:0]        oval_r    [NUM_SEQUENCES];
  logic [7:0]        mem       [NUM_SEQUENCES][TABLE_DEPTH];
  logic [7:0]        mem_q;

  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic              in_acc;
  logic              tbl_wr;
  setup_t            cur;
  seq_state_t        st;
  logic [7:0]        pos;
  seq_state_t        st_nxt;
  logic [7:0]        pos_nxt;
  logic [8:0]        p;
  logic              need_rd;
  logic [8:0]        rd_idx;
  logic              rd_ok;
  logic              wr_out;
  logic [7:0]        out_new;
  out_item_t         res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[CFG_AW-1:2];
  assign in_stall = (fsm_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign tbl_wr   = in_acc && (in_data.op == OP_WRITE) &&
                    (in_data.table_select < 3'(NUM_SEQUENCES)) &&
                    ({1'b0, in_data.entry_index} < DEPTH_LIM);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEQUENCES; i++) begin
        setup_r[i] <= '0;
      end
      dvol_r <= DVOL_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx < 3'(NUM_SEQUENCES)) begin
        setup_r[cfg_idx[SEL_W-1:0]] <= pwdata[SETUP_W-1:0];
      end else if (cfg_idx == REG_DEFAULT_VOLUME) begin
        dvol_r <= pwdata[DVOL_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx < 3'(NUM_SEQUENCES)) begin
      prdata = CFG_DW'(setup_r[cfg_idx[SEL_W-1:0]]);
    end else if (cfg_idx == REG_DEFAULT_VOLUME) begin
      prdata = CFG_DW'(dvol_r);
    end
  end

  assign cur = setup_r[seq_r];
  assign st  = sstate_r[seq_r];
  assign pos = pos_r[seq_r];

  always_comb begin
    st_nxt  = st;
    pos_nxt = pos;
    need_rd = 1'b0;
    rd_idx  = '0;
    wr_out  = 1'b0;
    out_new = '0;
    p       = {1'b0, pos} + 9'd1;
    case (op_r)
      OP_TICK: begin
        if ((st == SEQ_PLAY || st == SEQ_REL) && cur.len != 8'd0) begin
          if (st == SEQ_PLAY && cur.rel_on && p > {1'b0, cur.rel}) begin
            p = cur.loop_on ? {1'b0, cur.loop} : {1'b0, cur.rel};
          end
          if (st == SEQ_REL && !cur.rel_on) begin
            st_nxt  = SEQ_STOP;
            pos_nxt = p[8] ? 8'hFF : p[7:0];
            if (seq_r == '0) begin
              wr_out = 1'b1;
            end
          end else begin
            if (p >= {1'b0, cur.len}) begin
              if (!cur.loop_on) begin
                p      = {1'b0, cur.len} - 9'd1;
                st_nxt = SEQ_STOP;
              end else begin
                p = {1'b0, cur.loop};
                if (p >= {1'b0, cur.len}) begin
                  p = {1'b0, cur.len} - 9'd1;
                end
              end
            end
            pos_nxt = p[7:0];
            need_rd = 1'b1;
            rd_idx  = p;
          end
        end
      end
      OP_NOTE_ON: begin
        pos_nxt = '0;
        if (cur.en) begin
          st_nxt  = SEQ_PLAY;
          need_rd = 1'b1;
        end else begin
          st_nxt  = SEQ_STOP;
          wr_out  = 1'b1;
          out_new = (seq_r == '0) ? 8'(dvol_r) : 8'd0;
        end
      end
      OP_NOTE_OFF: begin
        if (cur.en) begin
          if (st != SEQ_STOP && cur.rel_on) begin
            pos_nxt = cur.rel;
          end
          st_nxt = SEQ_REL;
        end else begin
          st_nxt = SEQ_STOP;
          wr_out = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_ok = (rd_idx < {1'b0, cur.len}) && (rd_idx < DEPTH_LIM);

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      mem[in_data.table_select[SEL_W-1:0]][in_data.entry_index[TIDX_W-1:0]] <=
        in_data.entry_value;
    end
    if (fsm_r == ST_CALC && need_rd && rd_ok) begin
      mem_q <= mem[seq_r][rd_idx[TIDX_W-1:0]];
    end
  end

  always_comb begin
    res.volume_value   = oval_r[0];
    res.arpeggio_value = oval_r[1];
    res.pitch_value    = oval_r[2];
    res.hipitch_value  = oval_r[3];
    res.duty_value     = oval_r[4];
    for (int i = 0; i < NUM_SEQUENCES; i++) begin
      res.playing_mask[i]   = (sstate_r[i] == SEQ_PLAY);
      res.releasing_mask[i] = (sstate_r[i] == SEQ_REL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      seq_r       <= '0;
      op_r        <= OP_TICK;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SEQUENCES; i++) begin
        sstate_r[i] <= SEQ_STOP;
        pos_r[i]    <= '0;
        oval_r[i]   <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && fsm_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (fsm_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r  <= in_data.op;
            seq_r <= '0;
            case (in_data.op)
              OP_TICK, OP_NOTE_ON, OP_NOTE_OFF: begin
                fsm_r <= ST_CALC;
              end
              OP_CUT: begin
                for (int i = 0; i < NUM_SEQUENCES; i++) begin
                  sstate_r[i] <= SEQ_STOP;
                  pos_r[i]    <= '0;
                  oval_r[i]   <= '0;
                end
                fsm_r <= ST_FIN;
              end
              default: begin
                fsm_r <= ST_FIN;
              end
            endcase
          end
        end
        ST_CALC: begin
          sstate_r[seq_r] <= st_nxt;
          pos_r[seq_r]    <= pos_nxt;
          if (wr_out) begin
            oval_r[seq_r] <= out_new;
          end
          if (need_rd) begin
            rd_ok_r <= rd_ok;
            fsm_r   <= ST_READ;
          end else if (seq_r == LAST_SEQ) begin
            fsm_r <= ST_FIN;
          end else begin
            seq_r <= seq_r + 1'b1;
          end
        end
        ST_READ: begin
          oval_r[seq_r] <= rd_ok_r ? mem_q : 8'd0;
          if (seq_r == LAST_SEQ) begin
            fsm_r <= ST_FIN;
          end else begin
            seq_r <= seq_r + 1'b1;
            fsm_r <= ST_CALC;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res;
            out_valid_r <= 1'b1;
            fsm_r       <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

/* sv/ies_checker.sv */
// ----------------------------------------------------------------------------
// Instrument envelope sequencer port checker
// Port-level properties of the sequencer, bound onto the top level.
// ----------------------------------------------------------------------------
`include "instrument_envelope_sequencer_assert.svh"

module ies_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ies_pkg::out_item_t out_data
);
  import ies_pkg::*;

  `IES_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `IES_ASSERT_NOW(a_mask_disjoint, out_valid, (out_data.playing_mask & out_data.releasing_mask) == 5'd0, "sequence both playing and releasing")
  `IES_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while previous beat in work")
  `IES_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result beat without work in progress")

endmodule

bind instrument_envelope_sequencer ies_checker u_ies_checker (.*);
